FILE: src/huffman_tree_build_and_decode_macros.svh
// Assertion macros shared by the checker of the Huffman tree block.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef HUFFMAN_TREE_BUILD_AND_DECODE_MACROS_SVH
`define HUFFMAN_TREE_BUILD_AND_DECODE_MACROS_SVH

// Condition in this cycle implies property in this cycle.
`define HTB_ASSERT_IMPLY(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("htb assertion failed");

// Condition in this cycle implies property in the next cycle.
`define HTB_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("htb assertion failed");

`endif

FILE: src/htb_pkg.sv
// Package of the Huffman tree build and decode block.
// Holds command codes, status codes, sequencer states and field widths.
`timescale 1ns / 1ps
`default_nettype none

package htb_pkg;

    localparam int WEIGHT_W      = 16;
    localparam int NODE_WEIGHT_W = 22;
    localparam int SYM_W         = 8;
    localparam int CODE_W        = 63;
    localparam int CLEN_W        = 6;
    localparam int CFG_W         = 7;
    localparam int IN_DATA_W     = 32;
    localparam int OUT_DATA_W    = 80;
    localparam int OUT_USER_W    = 4;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_BUILD  = 2'd1,
        FUNC_DECODE = 2'd2,
        FUNC_CODE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TRUNCATED = 2'd1,
        STATUS_NOT_BUILT = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_MERGE_A,
        ST_MERGE_B,
        ST_DEC_NODE,
        ST_DEC_CHILD,
        ST_CODE_PARENT,
        ST_CODE_STEP,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

FILE: src/huffman_tree_build_and_decode.sv
// Huffman tree build and decode: top level with sequencer and node tables.
// Depends on htb_pkg and htb_ram.
//
// Usage:
//  cfg_we/cfg_wdata write leaf_count (saturated to 2..MAX_LEAVES); write it only
//  while the block is idle. Writing it, or loading a leaf, marks the tree unbuilt.
//  Input items (s_axis): tuser is the command (load, build, decode bit, read code),
//  tdata carries leaf index, weight, symbol and code bit, tlast the last bit of a
//  code string. Every item gives exactly one result item on m_axis.
//  Build time is set by a clearing pass over the node links and, for each merge,
//  a linear scan of the parent and weight tables, one entry per cycle. The result
//  item becomes valid in the same cycle in which the next item can be accepted.
//  One item is in work at a time; s_axis_tready is high while the sequencer is idle.
//  The result waits in an output register while the receiver stalls; the next item
//  is accepted meanwhile and its result waits in the sequencer until the register
//  frees.
//  Reset clears the built flag, the leaf count (to 2) and the output valid; the
//  node tables hold nothing defined until loaded and built.
`timescale 1ns / 1ps
`default_nettype none

module huffman_tree_build_and_decode #(
    parameter int MAX_LEAVES = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [htb_pkg::CFG_W-1:0]       cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // leaf_index[5:0], weight[21:6], symbol[29:22], code_bit[30], zero[31]
    input  wire logic [htb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // func[1:0]
    input  wire logic [1:0]                      s_axis_tuser,
    input  wire logic                            s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // decoded_symbol[7:0], code_bits[70:8], code_length[76:71], zero[79:77]
    output logic      [htb_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // status[1:0], symbol_valid[2], build_done[3]
    output logic      [htb_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

    localparam int LW = $clog2(MAX_LEAVES);
    localparam int NW = LW + 1;
    localparam int ND = 2 * MAX_LEAVES;
    localparam int WW = htb_pkg::NODE_WEIGHT_W;

    // control registers
    htb_pkg::state_t               state_reg, state_next;
    logic [htb_pkg::CFG_W-1:0]     leaf_count_reg, leaf_count_next;
    logic                          built_reg, built_next;
    logic [NW-1:0]                 pos_reg, pos_next;
    logic                          rd_v_reg, rd_v_next;
    logic                          has1_reg, has1_next;
    logic                          has2_reg, has2_next;
    logic                          m_valid_reg, m_valid_next;

    // working registers
    logic [NW-1:0]                 i_reg, i_next;
    logic [NW-1:0]                 k_reg, k_next;
    logic [NW-1:0]                 clr_reg, clr_next;
    logic [NW-1:0]                 rd_k_reg, rd_k_next;
    logic [NW-1:0]                 a_reg, a_next;
    logic [NW-1:0]                 b_reg, b_next;
    logic [WW-1:0]                 w1_reg, w1_next;
    logic [WW-1:0]                 w2_reg, w2_next;
    logic [NW-1:0]                 c_reg, c_next;
    logic [NW-1:0]                 f_reg, f_next;
    logic                          bit_reg, bit_next;
    logic                          last_reg, last_next;
    logic [htb_pkg::CLEN_W-1:0]    steps_reg, steps_next;
    logic [htb_pkg::CODE_W-1:0]    code_reg, code_next;
    logic [1:0]                    res_status_reg, res_status_next;
    logic                          res_valid_reg, res_valid_next;
    logic [htb_pkg::SYM_W-1:0]     res_sym_reg, res_sym_next;
    logic [htb_pkg::CODE_W-1:0]    res_code_reg, res_code_next;
    logic [htb_pkg::CLEN_W-1:0]    res_len_reg, res_len_next;
    logic                          res_done_reg, res_done_next;
    logic [htb_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic [htb_pkg::OUT_USER_W-1:0] m_user_reg, m_user_next;

    // memory ports
    logic                          w_we, p_we, lr_we, s_we;
    logic [NW-1:0]                 w_wa, w_ra, p_wa, p_ra, lr_wa, lr_ra;
    logic [LW-1:0]                 s_wa, s_ra;
    logic [WW-1:0]                 w_wd, w_rd;
    logic [NW-1:0]                 p_wd, p_rd;
    logic [2*NW-1:0]               lr_wd, lr_rd;
    logic [htb_pkg::SYM_W-1:0]     s_wd, s_rd;

    // input fields
    htb_pkg::func_t                in_func;
    logic [5:0]                    in_leaf;
    logic [htb_pkg::WEIGHT_W-1:0]  in_weight;
    logic [htb_pkg::SYM_W-1:0]     in_symbol;
    logic                          in_bit;

    // derived values
    logic                          accept;
    logic                          out_free;
    logic                          leaf_ok;
    logic [NW-1:0]                 leaf_node;
    logic [NW-1:0]                 root_node;
    logic [NW-1:0]                 n_node;
    logic                          issuing;
    logic                          cand;
    logic [NW-1:0]                 child;
    logic [NW-1:0]                 next_parent;
    logic [htb_pkg::CODE_W-1:0]    code_set;
    logic [htb_pkg::CFG_W-1:0]     cfg_sat;

    assign in_func   = htb_pkg::func_t'(s_axis_tuser);
    assign in_leaf   = s_axis_tdata[5:0];
    assign in_weight = s_axis_tdata[21:6];
    assign in_symbol = s_axis_tdata[29:22];
    assign in_bit    = s_axis_tdata[30];

    assign leaf_ok   = {1'b0, in_leaf} < leaf_count_reg;
    assign leaf_node = NW'(in_leaf[LW-1:0]) + NW'(1);
    assign root_node = NW'({leaf_count_reg, 1'b0} - 8'd1);
    assign n_node    = NW'(leaf_count_reg);

    assign s_axis_tready = (state_reg == htb_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // saturate the leaf count write
    always_comb
    begin
        if (cfg_wdata < 7'd2)
        begin
            cfg_sat = 7'd2;
        end
        else if (cfg_wdata > 7'(MAX_LEAVES))
        begin
            cfg_sat = 7'(MAX_LEAVES);
        end
        else
        begin
            cfg_sat = cfg_wdata;
        end
    end

    // node tables and leaf symbols
    htb_ram #(.WIDTH(WW), .DEPTH(ND)) u_weight (
        .clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd)
    );
    htb_ram #(.WIDTH(NW), .DEPTH(ND)) u_parent (
        .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd)
    );
    htb_ram #(.WIDTH(2 * NW), .DEPTH(ND)) u_child (
        .clk(clk), .we(lr_we), .waddr(lr_wa), .wdata(lr_wd), .raddr(lr_ra),
        .rdata(lr_rd)
    );
    htb_ram #(.WIDTH(htb_pkg::SYM_W), .DEPTH(MAX_LEAVES)) u_symbol (
        .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
    );

    // sequencer: next state, memory ports and result
    always_comb
    begin
        state_next      = state_reg;
        leaf_count_next = leaf_count_reg;
        built_next      = built_reg;
        pos_next        = pos_reg;
        rd_v_next       = 1'b0;
        has1_next       = has1_reg;
        has2_next       = has2_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        i_next          = i_reg;
        k_next          = k_reg;
        clr_next        = clr_reg;
        rd_k_next       = rd_k_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        w1_next         = w1_reg;
        w2_next         = w2_reg;
        c_next          = c_reg;
        f_next          = f_reg;
        bit_next        = bit_reg;
        last_next       = last_reg;
        steps_next      = steps_reg;
        code_next       = code_reg;
        res_status_next = res_status_reg;
        res_valid_next  = res_valid_reg;
        res_sym_next    = res_sym_reg;
        res_code_next   = res_code_reg;
        res_len_next    = res_len_reg;
        res_done_next   = res_done_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;

        w_we  = 1'b0;
        w_wa  = '0;
        w_wd  = '0;
        w_ra  = k_reg;
        p_we  = 1'b0;
        p_wa  = '0;
        p_wd  = '0;
        p_ra  = k_reg;
        lr_we = 1'b0;
        lr_wa = '0;
        lr_wd = '0;
        lr_ra = pos_reg;
        s_we  = 1'b0;
        s_wa  = in_leaf[LW-1:0];
        s_wd  = in_symbol;
        s_ra  = '0;

        issuing     = 1'b0;
        cand        = 1'b0;
        child       = bit_reg ? lr_rd[NW-1:0] : lr_rd[2*NW-1:NW];
        next_parent = p_rd;
        code_set    = code_reg;

        case (state_reg)
            htb_pkg::ST_IDLE:
            begin
                // child links of the current position and parent of the queried leaf
                lr_ra = pos_reg;
                p_ra  = leaf_node;
                if (accept)
                begin
                    res_status_next = htb_pkg::STATUS_OK;
                    res_valid_next  = 1'b0;
                    res_sym_next    = '0;
                    res_code_next   = '0;
                    res_len_next    = '0;
                    res_done_next   = 1'b0;
                    bit_next        = in_bit;
                    last_next       = s_axis_tlast;
                    case (in_func)
                        htb_pkg::FUNC_LOAD:
                        begin
                            if (leaf_ok)
                            begin
                                w_we = 1'b1;
                                w_wa = leaf_node;
                                w_wd = WW'(in_weight);
                                s_we = 1'b1;
                            end
                            built_next = 1'b0;
                            state_next = htb_pkg::ST_RESP;
                        end
                        htb_pkg::FUNC_BUILD:
                        begin
                            clr_next   = NW'(1);
                            state_next = htb_pkg::ST_CLEAR;
                        end
                        htb_pkg::FUNC_DECODE:
                        begin
                            if (!built_reg)
                            begin
                                res_status_next = htb_pkg::STATUS_NOT_BUILT;
                                state_next      = htb_pkg::ST_RESP;
                            end
                            else
                            begin
                                state_next = htb_pkg::ST_DEC_NODE;
                            end
                        end
                        htb_pkg::FUNC_CODE:
                        begin
                            if (!built_reg)
                            begin
                                res_status_next = htb_pkg::STATUS_NOT_BUILT;
                                state_next      = htb_pkg::ST_RESP;
                            end
                            else if (!leaf_ok)
                            begin
                                state_next = htb_pkg::ST_RESP;
                            end
                            else
                            begin
                                c_next     = leaf_node;
                                steps_next = '0;
                                code_next  = '0;
                                state_next = htb_pkg::ST_CODE_PARENT;
                            end
                        end
                        default:
                        begin
                            state_next = htb_pkg::ST_RESP;
                        end
                    endcase
                end
            end

            htb_pkg::ST_CLEAR:
            begin
                // drop all links of nodes 1 .. root
                p_we  = 1'b1;
                p_wa  = clr_reg;
                lr_we = 1'b1;
                lr_wa = clr_reg;
                if (clr_reg == root_node)
                begin
                    i_next     = n_node + NW'(1);
                    k_next     = NW'(1);
                    has1_next  = 1'b0;
                    has2_next  = 1'b0;
                    state_next = htb_pkg::ST_SCAN;
                end
                else
                begin
                    clr_next = clr_reg + NW'(1);
                end
            end

            htb_pkg::ST_SCAN:
            begin
                // issue one read per cycle, pick the two lightest parentless nodes
                issuing   = k_reg < i_reg;
                p_ra      = k_reg;
                w_ra      = k_reg;
                rd_v_next = issuing;
                rd_k_next = k_reg;
                if (issuing)
                begin
                    k_next = k_reg + NW'(1);
                end
                cand = rd_v_reg && (p_rd == '0);
                if (cand && (!has1_reg || w_rd < w1_reg))
                begin
                    w2_next   = w1_reg;
                    b_next    = a_reg;
                    has2_next = has1_reg;
                    w1_next   = w_rd;
                    a_next    = rd_k_reg;
                    has1_next = 1'b1;
                end
                else if (cand && (!has2_reg || w_rd < w2_reg))
                begin
                    w2_next   = w_rd;
                    b_next    = rd_k_reg;
                    has2_next = 1'b1;
                end
                if (!issuing && !rd_v_reg)
                begin
                    state_next = htb_pkg::ST_MERGE_A;
                end
            end

            htb_pkg::ST_MERGE_A:
            begin
                p_we       = 1'b1;
                p_wa       = a_reg;
                p_wd       = i_reg;
                state_next = htb_pkg::ST_MERGE_B;
            end

            htb_pkg::ST_MERGE_B:
            begin
                // append the new node
                p_we  = 1'b1;
                p_wa  = b_reg;
                p_wd  = i_reg;
                w_we  = 1'b1;
                w_wa  = i_reg;
                w_wd  = w1_reg + w2_reg;
                lr_we = 1'b1;
                lr_wa = i_reg;
                lr_wd = {a_reg, b_reg};
                if (i_reg == root_node)
                begin
                    built_next    = 1'b1;
                    pos_next      = root_node;
                    res_done_next = 1'b1;
                    state_next    = htb_pkg::ST_RESP;
                end
                else
                begin
                    i_next     = i_reg + NW'(1);
                    k_next     = NW'(1);
                    has1_next  = 1'b0;
                    has2_next  = 1'b0;
                    state_next = htb_pkg::ST_SCAN;
                end
            end

            htb_pkg::ST_DEC_NODE:
            begin
                // step to the child and fetch its links and symbol
                c_next     = child;
                lr_ra      = child;
                s_ra       = LW'(child - NW'(1));
                state_next = htb_pkg::ST_DEC_CHILD;
            end

            htb_pkg::ST_DEC_CHILD:
            begin
                if (lr_rd == '0)
                begin
                    res_valid_next = 1'b1;
                    res_sym_next   = s_rd;
                    pos_next       = root_node;
                end
                else
                begin
                    pos_next = c_reg;
                    if (last_reg)
                    begin
                        res_status_next = htb_pkg::STATUS_TRUNCATED;
                        pos_next        = root_node;
                    end
                end
                state_next = htb_pkg::ST_RESP;
            end

            htb_pkg::ST_CODE_PARENT:
            begin
                if (p_rd == '0)
                begin
                    state_next = htb_pkg::ST_RESP;
                end
                else
                begin
                    f_next     = p_rd;
                    lr_ra      = p_rd;
                    p_ra       = p_rd;
                    state_next = htb_pkg::ST_CODE_STEP;
                end
            end

            htb_pkg::ST_CODE_STEP:
            begin
                // one code bit per parent hop, leaf edge first
                if (lr_rd[2*NW-1:NW] != c_reg)
                begin
                    code_set[steps_reg] = 1'b1;
                end
                code_next  = code_set;
                steps_next = steps_reg + 6'd1;
                c_next     = f_reg;
                if (next_parent == '0 || steps_reg == 6'(htb_pkg::CODE_W - 1))
                begin
                    res_code_next = code_set;
                    res_len_next  = steps_reg + 6'd1;
                    state_next    = htb_pkg::ST_RESP;
                end
                else
                begin
                    f_next = next_parent;
                    lr_ra  = next_parent;
                    p_ra   = next_parent;
                end
            end

            htb_pkg::ST_RESP:
            begin
                // hand the result to the output register once it is free
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'b000, res_len_reg, res_code_reg, res_sym_reg};
                    m_user_next  = {res_done_reg, res_valid_reg, res_status_reg};
                    state_next   = htb_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = htb_pkg::ST_IDLE;
            end
        endcase

        // configuration write
        if (cfg_we)
        begin
            leaf_count_next = cfg_sat;
            built_next      = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= htb_pkg::ST_IDLE;
            leaf_count_reg <= 7'd2;
            built_reg      <= 1'b0;
            pos_reg        <= NW'(3);
            rd_v_reg       <= 1'b0;
            has1_reg       <= 1'b0;
            has2_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            leaf_count_reg <= leaf_count_next;
            built_reg      <= built_next;
            pos_reg        <= pos_next;
            rd_v_reg       <= rd_v_next;
            has1_reg       <= has1_next;
            has2_reg       <= has2_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        k_reg          <= k_next;
        clr_reg        <= clr_next;
        rd_k_reg       <= rd_k_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        w1_reg         <= w1_next;
        w2_reg         <= w2_next;
        c_reg          <= c_next;
        f_reg          <= f_next;
        bit_reg        <= bit_next;
        last_reg       <= last_next;
        steps_reg      <= steps_next;
        code_reg       <= code_next;
        res_status_reg <= res_status_next;
        res_valid_reg  <= res_valid_next;
        res_sym_reg    <= res_sym_next;
        res_code_reg   <= res_code_next;
        res_len_reg    <= res_len_next;
        res_done_reg   <= res_done_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

endmodule

`default_nettype wire

FILE: src/htb_ram.sv
// Synchronous single-write, single-read memory with registered read data.
// Used for the node tables and the leaf symbol table; no package use.
`timescale 1ns / 1ps
`default_nettype none

module htb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/htb_checker.sv
// Port-level checker for the Huffman tree block, bound to the top level.
// Depends on huffman_tree_build_and_decode_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "huffman_tree_build_and_decode_macros.svh"

module htb_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [79:0] m_axis_tdata,
    input wire logic [3:0]  m_axis_tuser
);

    // one item in work at a time
    `HTB_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a decoded symbol comes with status ok and no build flag
    `HTB_ASSERT_IMPLY(a_sym_ok, m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[1:0] == 2'd0 && !m_axis_tuser[3])

    // an empty code carries no bits
    `HTB_ASSERT_IMPLY(a_len_code, m_axis_tvalid && m_axis_tdata[76:71] == 6'd0, m_axis_tdata[70:8] == 63'd0)

    // a stalled result holds
    `HTB_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind huffman_tree_build_and_decode htb_checker u_htb_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for huffman_tree_build_and_decode: loads leaves, builds trees,
// reads codes and decodes bit strings against a cycle-free tree predictor.
// Depends on htb_pkg and the huffman_tree_build_and_decode RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_LIMIT = 120000;
    localparam int IDLE_PCT    = 14;
    localparam int ITEM_TARGET = 600;

    typedef struct packed {
        htb_pkg::func_t f;
        logic [5:0]  leaf;
        logic [15:0] w;
        logic [7:0]  sym;
        logic        cbit;
        logic        lastb;
    } cmd_t;

    typedef struct packed {
        htb_pkg::status_t st;
        logic        sv;
        logic [7:0]  ds;
        logic [62:0] code;
        logic [5:0]  clen;
        logic        done;
    } res_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [htb_pkg::CFG_W-1:0] cfg_wdata;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [htb_pkg::IN_DATA_W-1:0] s_axis_tdata;
    logic [1:0] s_axis_tuser;
    logic s_axis_tlast;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [htb_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [htb_pkg::OUT_USER_W-1:0] m_axis_tuser;

    huffman_tree_build_and_decode dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    // Tree mirror
    int unsigned tw[128];
    logic [6:0]  tpar[128];
    logic [6:0]  tlft[128];
    logic [6:0]  trgt[128];
    logic [7:0]  tsym[64];
    logic [6:0]  walk_pos;
    logic        built;
    int unsigned nleaves;

    cmd_t pending[$];
    res_t expected_results[$];
    cmd_t cur;
    int   queued_total;
    int   accepted_total;
    int   errors;
    int   stall_cnt;
    bit   in_taken;
    bit   calm;

    // Clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [6:0] root_node();
        return 7'((2 * nleaves - 1) & 127);
    endfunction

    // Merge the two lightest parentless nodes until the root is made
    function automatic void build_tree();
        int unsigned n, top, a, b;
        longint unsigned w1, w2;
        n = nleaves;
        top = 2 * n - 1;
        for (int i = 1; i <= top; i++)
        begin
            if (i > n)
                tw[i] = 0;
            tpar[i] = '0;
            tlft[i] = '0;
            trgt[i] = '0;
        end
        for (int i = n + 1; i <= top; i++)
        begin
            w1 = 64'hFFFF_FFFF_FF;
            w2 = 64'hFFFF_FFFF_FF;
            a = 0;
            b = 0;
            for (int k = 1; k < i; k++)
            begin
                if (tpar[k] != 0)
                    continue;
                if (tw[k] < w1)
                begin
                    w2 = w1;
                    b = a;
                    w1 = tw[k];
                    a = k;
                end
                else if (tw[k] < w2)
                begin
                    w2 = tw[k];
                    b = k;
                end
            end
            tpar[a] = 7'(i);
            tpar[b] = 7'(i);
            tlft[i] = 7'(a);
            trgt[i] = 7'(b);
            tw[i] = (tw[a] + tw[b]) & 32'h3F_FFFF;
        end
    endfunction

    // Work out the result of one accepted item and advance the mirror
    function automatic res_t tree_response(cmd_t c);
        res_t r;
        logic [6:0] p, ch, f;
        int steps;
        r = '0;
        r.st = htb_pkg::STATUS_OK;
        if (c.f == htb_pkg::FUNC_LOAD)
        begin
            if (c.leaf < nleaves)
            begin
                tw[c.leaf + 1] = c.w;
                tsym[c.leaf] = c.sym;
            end
            built = 1'b0;
        end
        else if (c.f == htb_pkg::FUNC_BUILD)
        begin
            build_tree();
            built = 1'b1;
            walk_pos = root_node();
            r.done = 1'b1;
        end
        else if (!built)
            r.st = htb_pkg::STATUS_NOT_BUILT;
        else if (c.f == htb_pkg::FUNC_DECODE)
        begin
            p = walk_pos;
            ch = c.cbit ? trgt[p] : tlft[p];
            if (tlft[ch] == 0 && trgt[ch] == 0)
            begin
                r.sv = 1'b1;
                r.ds = tsym[6'(ch - 1)];
                walk_pos = root_node();
            end
            else
            begin
                walk_pos = ch;
                if (c.lastb)
                begin
                    r.st = htb_pkg::STATUS_TRUNCATED;
                    walk_pos = root_node();
                end
            end
        end
        else if (c.leaf < nleaves)
        begin
            ch = 7'(c.leaf + 1);
            f = tpar[ch];
            steps = 0;
            while (f != 0 && steps < 63)
            begin
                if (tlft[f] != ch)
                    r.code[steps] = 1'b1;
                steps++;
                ch = f;
                f = tpar[f];
            end
            r.clen = 6'(steps);
        end
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Driver: present pending items and drive the result-side ready
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_taken)
            begin
                in_taken = 1'b0;
                if (pending.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    cur = pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= cur.f;
                    s_axis_tlast <= cur.lastb;
                    s_axis_tdata <= {1'b0, cur.cbit, cur.sym, cur.w, cur.leaf};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: predict on acceptance, check results, watch for a hang
    always @(posedge clk)
    begin
        res_t got, want;
        if (rst_n)
        begin
            stall_cnt++;
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(tree_response(cur));
                in_taken = 1'b1;
                accepted_total++;
                stall_cnt = 0;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                stall_cnt = 0;
                got.st = htb_pkg::status_t'(m_axis_tuser[1:0]);
                got.sv = m_axis_tuser[2];
                got.done = m_axis_tuser[3];
                got.ds = m_axis_tdata[7:0];
                got.code = m_axis_tdata[70:8];
                got.clen = m_axis_tdata[76:71];
                if (expected_results.size() == 0)
                    report("unexpected item", {60'd0, m_axis_tuser}, 64'd0);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.st != want.st)
                        report("status", got.st, want.st);
                    if (got.sv != want.sv)
                        report("symbol_valid", got.sv, want.sv);
                    if (got.ds != want.ds)
                        report("decoded_symbol", got.ds, want.ds);
                    if (got.code != want.code)
                        report("code_bits", got.code, want.code);
                    if (got.clen != want.clen)
                        report("code_length", got.clen, want.clen);
                    if (got.done != want.done)
                        report("build_done", got.done, want.done);
                end
            end
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send(htb_pkg::func_t f, int leaf, int w, int sym, bit cb, bit lb);
        cmd_t c;
        c.f = f;
        c.leaf = 6'(leaf);
        c.w = 16'(w);
        c.sym = 8'(sym);
        c.cbit = cb;
        c.lastb = lb;
        pending.push_back(c);
        queued_total++;
    endtask

    // Hold until every item is accepted and every result has come back
    task automatic wait_drained();
        wait (accepted_total == queued_total && expected_results.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_leaf_count(int v);
        int unsigned s;
        wait_drained();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= 7'(v);
        s = v & 127;
        nleaves = (s < 2) ? 2 : (s > 64) ? 64 : s;
        built = 1'b0;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_all(int mode);
        int w;
        for (int i = 0; i < nleaves; i++)
        begin
            case (mode)
                0: w = $urandom_range(65535);
                1: w = $urandom_range(3);
                default: w = (i < 16) ? (1 << i) : 65535 - $urandom_range(1);
            endcase
            send(htb_pkg::FUNC_LOAD, i, w, $urandom_range(255), $urandom_range(1),
                 $urandom_range(1));
        end
    endtask

    // Random mix of code queries, decode strings, occasional reloads and rebuilds
    task automatic random_traffic(int count);
        int len, op;
        for (int k = 0; k < count; k++)
        begin
            op = $urandom_range(99);
            if (op < 25)
                send(htb_pkg::FUNC_CODE, $urandom_range(63), $urandom_range(65535),
                     $urandom_range(255), $urandom_range(1), $urandom_range(1));
            else if (op < 90)
            begin
                len = $urandom_range(1, 12);
                for (int j = 0; j < len; j++)
                    send(htb_pkg::FUNC_DECODE, $urandom_range(63), $urandom_range(65535),
                         $urandom_range(255), $urandom_range(1), j == len - 1);
                k += len - 1;
            end
            else if (op < 95)
            begin
                send(htb_pkg::FUNC_LOAD, $urandom_range(63), $urandom_range(65535),
                     $urandom_range(255), $urandom_range(1), $urandom_range(1));
                send(htb_pkg::FUNC_DECODE, 0, 0, 0, $urandom_range(1), 1'b1);
                send(htb_pkg::FUNC_BUILD, 0, 0, 0, 0, 0);
                k += 2;
            end
            else
                send(htb_pkg::FUNC_BUILD, $urandom_range(63), 0, 0, 0, 0);
        end
    endtask

    // Stimulus
    initial
    begin
        int n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        nleaves = 2;
        built = 1'b0;
        walk_pos = 7'd3;
        errors = 0;
        stall_cnt = 0;
        queued_total = 0;
        accepted_total = 0;
        in_taken = 1'b0;
        calm = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: commands before build, extreme leaves, ignored load, both bits
        send(htb_pkg::FUNC_DECODE, 0, 0, 0, 1'b1, 1'b1);
        send(htb_pkg::FUNC_CODE, 0, 0, 0, 1'b0, 1'b0);
        send(htb_pkg::FUNC_LOAD, 0, 65535, 255, 1'b1, 1'b1);
        send(htb_pkg::FUNC_LOAD, 1, 0, 0, 1'b0, 1'b0);
        send(htb_pkg::FUNC_LOAD, 63, 1234, 77, 1'b0, 1'b0);
        send(htb_pkg::FUNC_BUILD, 0, 0, 0, 0, 0);
        send(htb_pkg::FUNC_CODE, 0, 0, 0, 0, 0);
        send(htb_pkg::FUNC_CODE, 1, 0, 0, 0, 0);
        send(htb_pkg::FUNC_CODE, 63, 0, 0, 0, 0);
        send(htb_pkg::FUNC_DECODE, 0, 0, 0, 1'b0, 1'b0);
        send(htb_pkg::FUNC_DECODE, 0, 0, 0, 1'b1, 1'b1);

        // Directed: three leaves with equal weights, string ending inside a code
        write_leaf_count(3);
        for (int i = 0; i < 3; i++)
            send(htb_pkg::FUNC_LOAD, i, 5, 10 + i, 0, 0);
        send(htb_pkg::FUNC_BUILD, 0, 0, 0, 0, 0);
        send(htb_pkg::FUNC_DECODE, 0, 0, 0, 1'b1, 1'b1);
        send(htb_pkg::FUNC_DECODE, 0, 0, 0, 1'b1, 1'b0);
        send(htb_pkg::FUNC_DECODE, 0, 0, 0, 1'b1, 1'b0);
        send(htb_pkg::FUNC_CODE, 2, 0, 0, 0, 0);

        // Saturating writes: all-zero and all-one register values
        write_leaf_count(0);
        load_all(1);
        send(htb_pkg::FUNC_BUILD, 0, 0, 0, 0, 0);
        send(htb_pkg::FUNC_CODE, 1, 0, 0, 0, 0);
        write_leaf_count(127);
        load_all(2);
        send(htb_pkg::FUNC_BUILD, 0, 0, 0, 0, 0);
        for (int i = 0; i < 64; i += 9)
            send(htb_pkg::FUNC_CODE, i, 0, 0, 0, 0);
        random_traffic(40);

        // Random phases, each with its own leaf count and weight profile
        for (int ph = 0; queued_total < ITEM_TARGET; ph++)
        begin
            case ($urandom_range(9))
                0: n = 64;
                1: n = 2;
                2: n = $urandom_range(1) ? 1 : 100;
                default: n = $urandom_range(2, 16);
            endcase
            write_leaf_count(n);
            calm = (ph == 1);
            load_all($urandom_range(2));
            send(htb_pkg::FUNC_BUILD, 0, 0, 0, 0, 0);
            random_traffic(60);
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
